FILE: rtl/pbc_pkg.sv
// Package for the particle boundary pipeline: payload structs, register
// indexes, boundary modes and pipeline depth constants. No dependencies.
`default_nettype none
package pbc_pkg;

   localparam int unsigned NUM_AXES    = 3;
   localparam int unsigned DIM_DEFAULT = 3;
   localparam int unsigned DIV_BITS    = 33;            // |pos - lower| up to 2^32
   localparam int unsigned LATENCY     = DIV_BITS + 4;  // 2 front + divider + 2 back

   typedef enum logic [1:0] {
      MODE_ABSORB   = 2'd0,
      MODE_REFLECT  = 2'd1,
      MODE_PERIODIC = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE    = 3'd0,
      REG_LOWER_X = 3'd1,
      REG_UPPER_X = 3'd2,
      REG_LOWER_Y = 3'd3,
      REG_UPPER_Y = 3'd4,
      REG_LOWER_Z = 3'd5,
      REG_UPPER_Z = 3'd6,
      REG_UNUSED  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               keep;
   } rsp_type;

   // controls handed to one axis lane
   typedef struct packed {
      logic     en;      // pipeline advance
      logic     active;  // axis is below DIM
      mode_type mode;
   } axis_ctl_type;

   // per-stage side data of one axis lane
   typedef struct packed {
      logic signed [31:0] pos;
      logic [31:0]        vel;
      logic               neg;      // pos below lower
      logic               outside;
      logic               len_ok;   // upper > lower
      logic [31:0]        len;
   } axis_sb_type;

endpackage
`default_nettype wire

FILE: rtl/pbc_axis.sv
// One axis lane of the boundary pipeline: offset, bit-serial pipelined
// divider (one quotient bit per stage) and fold/wrap fix-up. Uses pbc_pkg.
`default_nettype none
module pbc_axis (
   input  wire                      clock,
   input  wire pbc_pkg::axis_ctl_type ctl,
   input  wire logic signed [31:0]  lower,
   input  wire logic signed [31:0]  upper,
   input  wire logic signed [31:0]  pos,
   input  wire logic signed [31:0]  vel,
   output logic signed [31:0]       new_pos,
   output logic signed [31:0]       new_vel,
   output logic                     out_of_box
);

   localparam int unsigned NB = pbc_pkg::DIV_BITS;

   // front stage 1: offsets
   logic signed [31:0] pos1_ff, vel1_ff;
   logic signed [32:0] d1_ff, len1_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         pos1_ff <= pos;
         vel1_ff <= vel;
         d1_ff   <= {pos[31], pos} - {lower[31], lower};
         len1_ff <= {upper[31], upper} - {lower[31], lower};
      end
   end

   // front stage 2: magnitude and range test
   pbc_pkg::axis_sb_type sb_ff [NB+1];
   logic [NB-1:0]        num_ff [NB+1];
   logic [31:0]          rem_ff [NB+1];
   logic                 qlsb_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         sb_ff[0].pos     <= pos1_ff;
         sb_ff[0].vel     <= vel1_ff;
         sb_ff[0].neg     <= d1_ff[32];
         sb_ff[0].outside <= (d1_ff < 33'sd0) || (d1_ff > len1_ff);
         sb_ff[0].len_ok  <= len1_ff > 33'sd0;
         sb_ff[0].len     <= len1_ff[31:0];
         num_ff[0]        <= d1_ff[32] ? (33'd0 - d1_ff) : d1_ff;
         rem_ff[0]        <= '0;
      end
   end

   // restoring divider, one bit per stage; remainder stays below len when len is nonzero
   logic [NB-1:0] ge;
   for (genvar i = 0; i < NB; i++) begin : g_div
      logic [32:0] trial;
      logic [32:0] diff;
      assign trial = {rem_ff[i], num_ff[i][NB-1]};
      assign diff  = trial - {1'b0, sb_ff[i].len};
      assign ge[i] = trial >= {1'b0, sb_ff[i].len};
      always_ff @(posedge clock) begin
         if (ctl.en) begin
            sb_ff[i+1]  <= sb_ff[i];
            num_ff[i+1] <= {num_ff[i][NB-2:0], 1'b0};
            rem_ff[i+1] <= ge[i] ? diff[31:0] : trial[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         qlsb_ff <= ge[NB-1];
      end
   end

   // back stage 1: offset from lower and velocity flip
   logic [31:0] rm, len_m_rm;
   logic        rm_zero;
   logic [31:0] off_in;
   logic        flip_in, fix_in;

   assign rm       = rem_ff[NB];
   assign len_m_rm = sb_ff[NB].len - rm;
   assign rm_zero  = rm == 32'd0;

   always_comb begin
      off_in  = rm;
      flip_in = 1'b0;
      fix_in  = ctl.active && sb_ff[NB].outside && sb_ff[NB].len_ok;
      unique case (ctl.mode)
         pbc_pkg::MODE_REFLECT: begin
            priority if (!sb_ff[NB].neg && !rm_zero) begin
               flip_in = qlsb_ff;
               off_in  = qlsb_ff ? len_m_rm : rm;
            end else if (!sb_ff[NB].neg) begin
               flip_in = !qlsb_ff;
               off_in  = qlsb_ff ? sb_ff[NB].len : 32'd0;
            end else if (!rm_zero) begin
               flip_in = !qlsb_ff;
               off_in  = qlsb_ff ? len_m_rm : rm;
            end else begin
               flip_in = qlsb_ff;
               off_in  = qlsb_ff ? sb_ff[NB].len : 32'd0;
            end
         end
         pbc_pkg::MODE_PERIODIC: begin
            off_in = (sb_ff[NB].neg && !rm_zero) ? len_m_rm : rm;
         end
         default: begin
            fix_in = 1'b0;
         end
      endcase
   end

   logic signed [31:0] pos5_ff, vel5_ff;
   logic [31:0]        off5_ff;
   logic               fix5_ff, flip5_ff, out5_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         pos5_ff  <= sb_ff[NB].pos;
         vel5_ff  <= sb_ff[NB].vel;
         off5_ff  <= off_in;
         fix5_ff  <= fix_in;
         flip5_ff <= fix_in && flip_in;
         out5_ff  <= ctl.active && sb_ff[NB].outside;
      end
   end

   // back stage 2: output register
   logic signed [31:0] pos6_ff, vel6_ff;
   logic               out6_ff;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         pos6_ff <= fix5_ff ? (lower + $signed(off5_ff)) : pos5_ff;
         vel6_ff <= flip5_ff ? (32'sd0 - vel5_ff) : vel5_ff;
         out6_ff <= out5_ff;
      end
   end

   assign new_pos    = pos6_ff;
   assign new_vel    = vel6_ff;
   assign out_of_box = out6_ff;

endmodule
`default_nettype wire

FILE: rtl/particle_boundary_condition.sv
// Top level of the particle box boundary block: configuration registers,
// valid pipeline and three pbc_axis lanes. Uses pbc_pkg and pbc_axis.
//
// One particle word in, one word out, through two offset stages, a
// 33-stage divider taking one quotient bit per stage and two fix-up
// stages. A word can enter every cycle while req_stall is low. The whole pipe
// advances together: when a result is held by rsp_stall, req_stall rises.
// Bounds and mode are read live, so write them only while the pipe is empty.
`default_nettype none
module particle_boundary_condition #(
   parameter int unsigned DIM = pbc_pkg::DIM_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire pbc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output pbc_pkg::rsp_type    rsp_data,
   input  wire                 csr_we,
   input  wire [2:0]           csr_index,
   input  wire [31:0]          csr_wdata
);

   localparam int unsigned LAT = pbc_pkg::LATENCY;
   localparam int unsigned NA  = pbc_pkg::NUM_AXES;

   // configuration
   pbc_pkg::mode_type  mode_ff;
   logic signed [31:0] lo_ff [NA];
   logic signed [31:0] hi_ff [NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pbc_pkg::MODE_ABSORB;
         for (int a = 0; a < NA; a++) begin
            lo_ff[a] <= 32'sd0;
            hi_ff[a] <= 32'sd65536;
         end
      end else if (csr_we) begin
         unique case (pbc_pkg::reg_index_type'(csr_index))
            pbc_pkg::REG_MODE:    mode_ff  <= pbc_pkg::mode_type'(csr_wdata[1:0]);
            pbc_pkg::REG_LOWER_X: lo_ff[0] <= csr_wdata;
            pbc_pkg::REG_UPPER_X: hi_ff[0] <= csr_wdata;
            pbc_pkg::REG_LOWER_Y: lo_ff[1] <= csr_wdata;
            pbc_pkg::REG_UPPER_Y: hi_ff[1] <= csr_wdata;
            pbc_pkg::REG_LOWER_Z: lo_ff[2] <= csr_wdata;
            pbc_pkg::REG_UPPER_Z: hi_ff[2] <= csr_wdata;
            default: ;  // unused index, ignored
         endcase
      end
   end

   // valid pipe; all stages move on one enable
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic           en;

   assign en     = !(vld_ff[LAT-1] && rsp_stall);
   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !en;
   assign rsp_valid = vld_ff[LAT-1];

   // axis lanes
   logic signed [31:0] pos_in [NA];
   logic signed [31:0] vel_in [NA];
   logic signed [31:0] pos_out [NA];
   logic signed [31:0] vel_out [NA];
   logic [NA-1:0]      outside;

   assign pos_in[0] = req_data.pos_x;
   assign pos_in[1] = req_data.pos_y;
   assign pos_in[2] = req_data.pos_z;
   assign vel_in[0] = req_data.vel_x;
   assign vel_in[1] = req_data.vel_y;
   assign vel_in[2] = req_data.vel_z;

   for (genvar a = 0; a < NA; a++) begin : g_axis
      pbc_pkg::axis_ctl_type ctl;
      assign ctl.en     = en;
      assign ctl.active = a < DIM;
      assign ctl.mode   = mode_ff;

      pbc_axis u_axis (
         .clock      (clock),
         .ctl        (ctl),
         .lower      (lo_ff[a]),
         .upper      (hi_ff[a]),
         .pos        (pos_in[a]),
         .vel        (vel_in[a]),
         .new_pos    (pos_out[a]),
         .new_vel    (vel_out[a]),
         .out_of_box (outside[a])
      );
   end

   assign rsp_data.new_pos_x = pos_out[0];
   assign rsp_data.new_pos_y = pos_out[1];
   assign rsp_data.new_pos_z = pos_out[2];
   assign rsp_data.new_vel_x = vel_out[0];
   assign rsp_data.new_vel_y = vel_out[1];
   assign rsp_data.new_vel_z = vel_out[2];
   // absorbed when any tested axis is out of the box in absorb mode
   assign rsp_data.keep      = !((mode_ff == pbc_pkg::MODE_ABSORB) && (|outside));

   // checks
   a_keep_absorb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.keep |-> mode_ff == pbc_pkg::MODE_ABSORB)
      else $error("particle dropped outside absorb mode");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result word changed");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall out of step with output stall");

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for particle_boundary_condition: directed and random particle
// words under absorb, reflect, periodic and unused modes. Depends on pbc_pkg and the RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbc_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type      req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type      rsp_data;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = 3'd0;
   logic [31:0]  csr_wdata = '0;

   particle_boundary_condition u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench copy of the register file
   mode_type    box_mode;
   logic [31:0] box_lo [NUM_AXES];
   logic [31:0] box_hi [NUM_AXES];

   rsp_type     pending_particles[$];
   int          fail_count = 0;

   // idling knobs, set per test
   bit          sender_idle = 1'b1;
   bit          receiver_idle = 1'b1;
   int          hold_requests = 0;   // bumped by a test to ask for a long hold-off
   int          hold_served = 0;
   int          hold_left = 0;

   // ---------------------------------------------------------------
   // Predictor: apply the box rule to one particle word
   // ---------------------------------------------------------------
   function automatic rsp_type boundary_rule(req_type p);
      longint pos [NUM_AXES];
      logic [31:0] vel [NUM_AXES];
      longint lo, hi, span, d, e, n, off, r;
      bit keep_bit;
      rsp_type res;
      keep_bit = 1'b1;
      pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
      vel[0] = p.vel_x; vel[1] = p.vel_y; vel[2] = p.vel_z;
      for (int a = 0; a < NUM_AXES; a++) begin
         lo = longint'($signed(box_lo[a]));
         hi = longint'($signed(box_hi[a]));
         span = hi - lo;
         d = pos[a] - lo;
         if (pos[a] >= lo && pos[a] <= hi) continue;
         case (box_mode)
            MODE_ABSORB: keep_bit = 1'b0;
            MODE_REFLECT: begin
               if (span > 0) begin
                  // fold by the mirror count; odd count flips the velocity
                  if (d > span) begin
                     n = (d + span - 1) / span - 1;
                     off = n[0] ? (n + 1) * span - d : d - n * span;
                  end else begin
                     e = -d;
                     n = (e + span - 1) / span;
                     off = n[0] ? e - (n - 1) * span : n * span - e;
                  end
                  pos[a] = lo + off;
                  if (n[0]) vel[a] = 32'd0 - vel[a];
               end
            end
            MODE_PERIODIC: begin
               if (span > 0) begin
                  r = d % span;
                  if (r < 0) r += span;
                  pos[a] = lo + r;
               end
            end
            default: ;
         endcase
      end
      res.new_pos_x = pos[0][31:0]; res.new_pos_y = pos[1][31:0];
      res.new_pos_z = pos[2][31:0];
      res.new_vel_x = vel[0]; res.new_vel_y = vel[1]; res.new_vel_z = vel[2];
      res.keep = keep_bit;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Result side: random stalls, long hold-offs on request, checking
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_particles.size() == 0) begin
               $display("%0t: unexpected word, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = pending_particles.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 300;          // long hold-off so the pipe backs up
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
            hold_left = idle_len();
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one word; returns at the edge that took it, or after a random idle gap when sender_idle is set
   task automatic send_particle(req_type p);
      int gap;
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      pending_particles.push_back(boundary_rule(p));
      gap = sender_idle ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // quiet the pipe before touching registers (bounds are read live)
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_particles.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == REG_MODE) box_mode = mode_type'(val[1:0]);
      else if (idx != REG_UNUSED) begin
         if (idx[0]) box_lo[(idx - 1) / 2] = val;
         else box_hi[(idx - 1) / 2] = val;
      end
   endtask

   task automatic set_box(mode_type m, logic [31:0] lo [NUM_AXES], logic [31:0] hi [NUM_AXES]);
      drain();
      csr_write(REG_MODE, {$urandom} & ~32'h3 | m);   // upper bits ignored
      for (int a = 0; a < NUM_AXES; a++) begin
         csr_write(reg_index_type'(2 * a + 1), lo[a]);
         csr_write(reg_index_type'(2 * a + 2), hi[a]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic req_type make_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                             logic [31:0] vx, logic [31:0] vy,
                                             logic [31:0] vz);
      req_type p;
      p.pos_x = px; p.pos_y = py; p.pos_z = pz;
      p.vel_x = vx; p.vel_y = vy; p.vel_z = vz;
      return p;
   endfunction

   // position near the box of one axis, sometimes anywhere
   function automatic logic [31:0] rand_coord(int a);
      longint lo, hi, span, v;
      lo = longint'($signed(box_lo[a]));
      hi = longint'($signed(box_hi[a]));
      span = (hi > lo) ? hi - lo : 64;
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: case ($urandom_range(0, 3))
               0: return lo[31:0];
               1: return hi[31:0];
               2: return lo[31:0] - 32'd1;
               default: return hi[31:0] + 32'd1;
            endcase
         3, 4: begin
            v = lo + longint'($urandom_range(0, 1000)) * span / 1000;
            return v[31:0];
         end
         default: begin
            v = lo + longint'($urandom_range(0, 7000)) * span / 1000 - 3 * span;
            if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
            if (v < -64'sh80000000) v = -64'sh80000000;
            return v[31:0];
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_vel();
      case ($urandom_range(0, 9))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_burst(int count);
      repeat (count)
         send_particle(make_particle(rand_coord(0), rand_coord(1), rand_coord(2),
                                     rand_vel(), rand_vel(), rand_vel()));
   endtask

   // random box per axis; extremes, unit and empty boxes now and then
   task automatic random_box(mode_type m);
      logic [31:0] lo [NUM_AXES];
      logic [31:0] hi [NUM_AXES];
      longint l, h;
      for (int a = 0; a < NUM_AXES; a++) begin
         case ($urandom_range(0, 9))
            0: begin l = -64'sh80000000; h = 64'sh7FFFFFFF; end
            1: begin l = $signed($urandom); h = l + 1; end
            2: begin l = $signed($urandom); h = l - $urandom_range(0, 5); end
            3: begin l = $signed($urandom); h = $signed($urandom); end
            default: begin
               l = $signed($urandom) >>> $urandom_range(0, 12);
               h = l + ($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 28)) + 1;
            end
         endcase
         if (h > 64'sh7FFFFFFF) h = 64'sh7FFFFFFF;
         if (h < -64'sh80000000) h = -64'sh80000000;
         lo[a] = l[31:0];
         hi[a] = h[31:0];
      end
      set_box(m, lo, hi);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // reset values: absorb, unit box on every axis
   task automatic test_reset_defaults();
      send_particle(make_particle(32'd0, 32'd65536, 32'd32768, 32'd1, 32'd2, 32'd3));
      send_particle(make_particle(32'hFFFFFFFF, 32'd0, 32'd65537, 32'd4, 32'd5, 32'd6));
   endtask

   task automatic test_modes_directed();
      logic [31:0] lo [NUM_AXES] = '{32'hFFFF0000, 32'h80000000, 32'd0};
      logic [31:0] hi [NUM_AXES] = '{32'h00010000, 32'h7FFFFFFF, 32'd3};
      mode_type m;
      for (int k = 0; k < 4; k++) begin
         m = mode_type'(k);
         set_box(m, lo, hi);
         send_particle(make_particle(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                     32'h80000000, 32'h7FFFFFFF, 32'd1));
         send_particle(make_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd4,
                                     32'd5, 32'h80000000, 32'hFFFFFFFF));
         send_particle(make_particle(32'h00020001, 32'd0, 32'hFFFFFFFA,
                                     32'd9, 32'd9, 32'h80000000));
         send_particle(make_particle(32'hFFFF0000, 32'd7, 32'd3, 32'd1, 32'd2, 32'd3));
      end
   endtask

   // empty and degenerate boxes: reflect and wrap leave the axis alone
   task automatic test_empty_box();
      logic [31:0] lo [NUM_AXES] = '{32'd100, 32'd50, 32'h7FFFFFFF};
      logic [31:0] hi [NUM_AXES] = '{32'd100, 32'd10, 32'h80000000};
      for (int k = 0; k < 3; k++) begin
         set_box(mode_type'(k), lo, hi);
         send_particle(make_particle(32'd101, 32'd20, 32'd0, 32'd1, 32'd2, 32'd3));
         send_particle(make_particle(32'd100, 32'd50, 32'h7FFFFFFF, 32'd1, 32'd2, 32'd3));
      end
   endtask

   // a write to the unused index must change nothing
   task automatic test_unused_index();
      drain();
      csr_write(REG_UNUSED, $urandom);
      csr_we <= 1'b0;
      send_particle(make_particle(32'd200, 32'd1, 32'd2, 32'd7, 32'd8, 32'd9));
   endtask

   task automatic test_random_modes();
      mode_type order [6] = '{MODE_REFLECT, MODE_PERIODIC, MODE_ABSORB,
                              MODE_REFLECT, MODE_PERIODIC, MODE_NONE};
      for (int ph = 0; ph < 6; ph++) begin
         random_box(order[ph]);
         // one stretch with no idling on either side
         sender_idle = (ph != 3);
         receiver_idle = (ph != 3);
         random_burst(ph == 5 ? 100 : 300);
         if (ph != 3) begin
            random_box(order[ph]);
            random_burst(ph == 5 ? 20 : 50);
         end
      end
      sender_idle = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering: pipe fills, req_stall rises
   task automatic test_backpressure();
      random_box(MODE_REFLECT);
      sender_idle = 1'b0;
      hold_requests <= hold_requests + 1;
      random_burst(120);
      sender_idle = 1'b1;
   endtask

   initial begin
      box_mode = MODE_ABSORB;
      for (int a = 0; a < NUM_AXES; a++) begin
         box_lo[a] = 32'd0;
         box_hi[a] = 32'd65536;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_modes_directed();
      test_empty_box();
      test_unused_index();
      test_random_modes();
      test_backpressure();

      drain();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/pbc_pkg.sv
rtl/pbc_axis.sv
rtl/particle_boundary_condition.sv
bench/tb.sv
